// File: rtl/go_back_n_link_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// go_back_n_link_engine_unit_defines
// Assertion macros used by the link engine datapath.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_LINK_ENGINE_UNIT_DEFINES_SVH
`define GO_BACK_N_LINK_ENGINE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define GBN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle.
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBN_ASSERT(label, prop, msg)
`define GBN_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Constants, codes, control types and CRC helpers of the link engine.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_W      = 3;
    localparam int SEQ_MOD    = 1 << SEQ_W;
    localparam logic [SEQ_W-1:0] WIN_MAX = 3'd7;
    localparam int INFO_W     = 10;
    localparam int HDR_W      = 16;
    localparam int CRC_W      = 16;
    localparam int FRAME_W    = HDR_W + CRC_W;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam int CRC_STEPS  = HDR_W / 2;
    localparam int CRC_CNT_W  = $clog2(CRC_STEPS);
    localparam int ACK_CNT_W  = SEQ_W + 1;

    localparam int TIMEOUT_W  = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd15;
    localparam int AGE_BITS_DEF = 16;

    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int IN_TDATA_W  = FRAME_W;
    localparam int OUT_TDATA_W = FRAME_W + INFO_W + SEQ_W + SEQ_W;
    localparam int OUT_TUSER_W = STATUS_W + 1;

    localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RX   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SENT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WIN_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IN_ORDER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUT_ORDER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IDLE_TICK = 3'd6;

    typedef struct packed {
        logic start;
        logic crc_step;
        logic eval;
        logic rel_step;
        logic age;
        logic chk;
        logic load_out;
    } gbn_cmd_t;

    typedef struct packed {
        logic win_full;
        logic crc_last;
        logic rx_good;
        logic rel_done;
        logic out_free;
    } gbn_stat_t;

    function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc,
                                                 input logic b);
        logic [CRC_W-1:0] nxt;
        nxt = {crc[CRC_W-2:0], 1'b0};
        if (crc[CRC_W-1] ^ b)
        begin
            nxt = nxt ^ CRC_POLY;
        end
        return nxt;
    endfunction

    // Two message bits per call, higher bit first.
    function automatic logic [CRC_W-1:0] crc_step2(input logic [CRC_W-1:0] crc,
                                                   input logic [1:0] bits);
        return crc_bit(crc_bit(crc, bits[1]), bits[0]);
    endfunction

endpackage

// File: rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer of the link engine: steps an item through CRC, update and ack
// release or a tick through aging and check, then feeds the output register.
// ----------------------------------------------------------------------------
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [FUNC_W-1:0] func,
    input  gbn_stat_t         stat,
    output gbn_cmd_t          cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CRC  = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_REL  = 3'd3;
    localparam logic [2:0] S_AGE  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.start = 1'b1;
                    case (func)
                        FUNC_SEND: state_next = stat.win_full ? S_DONE : S_CRC;
                        FUNC_RX:   state_next = S_CRC;
                        FUNC_TICK: state_next = S_AGE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_CRC:
            begin
                cmd.crc_step = 1'b1;
                if (stat.crc_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.rx_good ? S_REL : S_DONE;
            end
            S_REL:
            begin
                if (stat.rel_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rel_step = 1'b1;
                end
            end
            S_AGE:
            begin
                cmd.age    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.chk    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold the result until the output register frees up.
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp
// Datapath of the link engine: window state, slot timers, serial CRC,
// result registers and the output register.
// ----------------------------------------------------------------------------
`include "go_back_n_link_engine_unit_defines.svh"

module gbn_dp
    import gbn_pkg::*;
#(
    parameter int AGE_BITS = AGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [TIMEOUT_W-1:0]   cfg_wr_data,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0]      s_tuser,
    input  gbn_cmd_t               cmd,
    output gbn_stat_t              stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    localparam int CMP_W = (AGE_BITS > TIMEOUT_W) ? AGE_BITS : TIMEOUT_W;

    // window and timer state
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [SEQ_W-1:0]     send_seq_reg, send_seq_next;
    logic [SEQ_W-1:0]     oldest_reg, oldest_next;
    logic [SEQ_W-1:0]     expected_reg, expected_next;
    logic [SEQ_W-1:0]     fill_reg, fill_next;
    logic [INFO_W-1:0]    info_reg, info_next;
    logic [SEQ_MOD-1:0]   active_reg, active_next;
    logic [AGE_BITS-1:0]  age_reg [SEQ_MOD];
    logic [AGE_BITS-1:0]  age_next [SEQ_MOD];

    // per-item working registers
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [HDR_W-1:0]     hdr_reg, hdr_next;
    logic [CRC_W-1:0]     rx_crc_reg, rx_crc_next;
    logic [CRC_W-1:0]     crc_reg, crc_next;
    logic [HDR_W-1:0]     crc_sh_reg, crc_sh_next;
    logic [CRC_CNT_W-1:0] crc_cnt_reg, crc_cnt_next;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 res_txv_reg, res_txv_next;
    logic [FRAME_W-1:0]   res_frame_reg, res_frame_next;
    logic [INFO_W-1:0]    res_info_reg, res_info_next;
    logic [ACK_CNT_W-1:0] res_acked_reg, res_acked_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic [HDR_W-1:0]   send_hdr;
    logic [SEQ_W-1:0]   hdr_seq;
    logic [SEQ_W-1:0]   hdr_ack;
    logic               crc_ok;
    logic               in_win;
    logic [SEQ_MOD-1:0] over;
    logic               fire;

    assign send_hdr = {send_seq_reg, SEQ_W'(expected_reg - 1'b1), info_reg};
    assign hdr_seq  = hdr_reg[HDR_W-1 -: SEQ_W];
    assign hdr_ack  = hdr_reg[HDR_W-SEQ_W-1 -: SEQ_W];
    assign crc_ok   = (crc_reg == rx_crc_reg);

    // ack lies in [oldest, send_seq) in circular order
    assign in_win = ((oldest_reg <= hdr_ack) && (hdr_ack < send_seq_reg))
                 || ((send_seq_reg < oldest_reg) && (oldest_reg <= hdr_ack))
                 || ((send_seq_reg < oldest_reg) && (hdr_ack < send_seq_reg));

    always_comb
    begin
        for (int k = 0; k < SEQ_MOD; k++)
        begin
            over[k] = active_reg[k] && (CMP_W'(age_reg[k]) >= CMP_W'(timeout_reg));
        end
    end

    assign fire = |over;

    assign stat.win_full = (fill_reg >= WIN_MAX);
    assign stat.crc_last = (crc_cnt_reg == CRC_CNT_W'(CRC_STEPS - 1));
    assign stat.rx_good  = (func_reg == FUNC_RX) && crc_ok;
    assign stat.rel_done = !in_win || res_acked_reg[ACK_CNT_W-1];
    assign stat.out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        timeout_next    = timeout_reg;
        send_seq_next   = send_seq_reg;
        oldest_next     = oldest_reg;
        expected_next   = expected_reg;
        fill_next       = fill_reg;
        info_next       = info_reg;
        active_next     = active_reg;
        age_next        = age_reg;
        func_next       = func_reg;
        hdr_next        = hdr_reg;
        rx_crc_next     = rx_crc_reg;
        crc_next        = crc_reg;
        crc_sh_next     = crc_sh_reg;
        crc_cnt_next    = crc_cnt_reg;
        res_status_next = res_status_reg;
        res_txv_next    = res_txv_reg;
        res_frame_next  = res_frame_reg;
        res_info_next   = res_info_reg;
        res_acked_next  = res_acked_reg;
        m_valid_next    = m_valid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (cfg_wr_en)
        begin
            timeout_next = cfg_wr_data;
        end

        if (cmd.start)
        begin
            func_next    = s_tuser;
            hdr_next     = (s_tuser == FUNC_SEND) ? send_hdr : s_tdata[FRAME_W-1:CRC_W];
            rx_crc_next  = s_tdata[CRC_W-1:0];
            crc_next     = '0;
            crc_sh_next  = (s_tuser == FUNC_SEND) ? send_hdr : s_tdata[FRAME_W-1:CRC_W];
            crc_cnt_next = '0;
            res_status_next = ((s_tuser == FUNC_SEND) && stat.win_full) ? ST_WIN_FULL
                                                                        : ST_IDLE_TICK;
            res_txv_next   = 1'b0;
            res_frame_next = '0;
            res_info_next  = '0;
            res_acked_next = '0;
        end

        if (cmd.crc_step)
        begin
            crc_next     = crc_step2(crc_reg, crc_sh_reg[HDR_W-1 -: 2]);
            crc_sh_next  = {crc_sh_reg[HDR_W-3:0], 2'b00};
            crc_cnt_next = crc_cnt_reg + 1'b1;
        end

        if (cmd.eval)
        begin
            if (func_reg == FUNC_SEND)
            begin
                res_status_next = ST_SENT;
                res_txv_next    = 1'b1;
                res_frame_next  = {hdr_reg, crc_reg};
                active_next[send_seq_reg] = 1'b1;
                age_next[send_seq_reg]    = '0;
                send_seq_next = send_seq_reg + 1'b1;
                fill_next     = fill_reg + 1'b1;
                info_next     = info_reg + 1'b1;
            end
            else if (!crc_ok)
            begin
                res_status_next = ST_CRC_ERR;
            end
            else
            begin
                res_info_next = hdr_reg[INFO_W-1:0];
                if (hdr_seq == expected_reg)
                begin
                    expected_next   = expected_reg + 1'b1;
                    res_status_next = ST_IN_ORDER;
                end
                else
                begin
                    res_status_next = ST_OUT_ORDER;
                end
            end
        end

        // Release one slot per cycle while the ack still covers the oldest one.
        if (cmd.rel_step && in_win && !res_acked_reg[ACK_CNT_W-1])
        begin
            if (fill_reg != '0)
            begin
                fill_next = fill_reg - 1'b1;
            end
            active_next[oldest_reg] = 1'b0;
            age_next[oldest_reg]    = '0;
            oldest_next    = oldest_reg + 1'b1;
            res_acked_next = res_acked_reg + 1'b1;
        end

        if (cmd.age)
        begin
            for (int k = 0; k < SEQ_MOD; k++)
            begin
                if (active_reg[k] && (age_reg[k] != {AGE_BITS{1'b1}}))
                begin
                    age_next[k] = age_reg[k] + 1'b1;
                end
            end
        end

        // Go back: rewind sequence and info, drop the whole window.
        if (cmd.chk && fire)
        begin
            send_seq_next = oldest_reg;
            info_next     = info_reg - INFO_W'(fill_reg);
            fill_next     = '0;
            active_next   = '0;
            for (int k = 0; k < SEQ_MOD; k++)
            begin
                age_next[k] = '0;
            end
            res_status_next = ST_TIMEOUT;
        end

        if (cmd.load_out)
        begin
            m_valid_next = 1'b1;
            m_tdata_next = {fill_reg, res_acked_reg[SEQ_W-1:0], res_info_reg, res_frame_reg};
            m_tuser_next = {res_txv_reg, res_status_reg};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RST;
            send_seq_reg <= '0;
            oldest_reg   <= '0;
            expected_reg <= '0;
            fill_reg     <= '0;
            info_reg     <= '0;
            active_reg   <= '0;
            for (int k = 0; k < SEQ_MOD; k++)
            begin
                age_reg[k] <= '0;
            end
            func_reg      <= FUNC_SEND;
            crc_cnt_reg   <= '0;
            res_acked_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            send_seq_reg  <= send_seq_next;
            oldest_reg    <= oldest_next;
            expected_reg  <= expected_next;
            fill_reg      <= fill_next;
            info_reg      <= info_next;
            active_reg    <= active_next;
            age_reg       <= age_next;
            func_reg      <= func_next;
            crc_cnt_reg   <= crc_cnt_next;
            res_acked_reg <= res_acked_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg        <= hdr_next;
        rx_crc_reg     <= rx_crc_next;
        crc_reg        <= crc_next;
        crc_sh_reg     <= crc_sh_next;
        res_status_reg <= res_status_next;
        res_txv_reg    <= res_txv_next;
        res_frame_reg  <= res_frame_next;
        res_info_reg   <= res_info_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `GBN_ASSERT(a_fill_bound, fill_reg <= WIN_MAX, "window fill above maximum")
    `GBN_ASSERT(a_fill_span, SEQ_W'(send_seq_reg - oldest_reg) == fill_reg, "fill disagrees with window span")
    `GBN_ASSERT(a_load_free, !cmd.load_out || !m_valid_reg || m_tready, "result loaded over a pending beat")
    `GBN_ASSERT_NEXT(a_timeout_clear, cmd.chk && fire, fill_reg == '0 && active_reg == '0, "window not dropped on timeout")

endmodule

// File: rtl/go_back_n_link_engine_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_link_engine_unit
// Go-Back-N ARQ link engine with 3-bit sequence numbers and CRC-16 frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a command in s_axis_tuser (send, received frame, timer
//   tick) and a received frame in s_axis_tdata. Each input beat yields
//   exactly one output beat: status and tx flag in m_axis_tuser, built frame,
//   received info, released slot count and outstanding count in m_axis_tdata.
//   The engine works on one beat at a time. A send or receive runs the CRC
//   two bits a cycle over the 16-bit header, then evaluates the frame; a
//   received frame with a good CRC then releases acked slots. A send into a
//   full window or any other command goes straight to the output, and a tick
//   ages the slot timers and checks them. The next beat is accepted in the cycle
//   after the result moves to the output register.
//   The output register holds a finished beat while m_axis_tready is low;
//   the engine can accept and work one more item meanwhile, then waits.
//   Reset empties the window, zeroes all counters and timers and sets the
//   timeout to 15 ticks. Write timeout_ticks through cfg_wr_en/cfg_wr_data
//   only while the engine is idle.
// ----------------------------------------------------------------------------
module go_back_n_link_engine_unit
    import gbn_pkg::*;
#(
    parameter int AGE_BITS = AGE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [TIMEOUT_W-1:0]   cfg_wr_data,    // timeout_ticks
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // rx_frame[31:0]
    input  logic [FUNC_W-1:0]      s_axis_tuser,   // func[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tx_frame[31:0], rx_info[41:32], acked_count[44:42], outstanding[47:45]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[2:0], tx_valid[3]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    gbn_cmd_t  cmd;
    gbn_stat_t stat;

    gbn_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .func          (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    gbn_dp #(
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser)
    );

endmodule
